[hdl/fes_pkg.sv]
`default_nettype none
package fes_pkg;

  localparam int WORD_W    = 32;
  localparam int NGRAD     = 9;
  localparam int NDIR      = 3;
  localparam int NCOMP     = 6;
  localparam int IN_W      = (NGRAD + NDIR) * WORD_W;
  localparam int OUT_W     = NCOMP * WORD_W;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // iterative log2 / exp2 units: one bit of the 24-bit fraction per stage
  localparam int ITERS     = 24;
  localparam int UNIT_LAT  = ITERS + 1;
  localparam int FRONT_LAT = 4;
  // front, logs, two exponent stages, T, sum, argument, output exp2, final
  localparam int TOT_LAT   = FRONT_LAT + UNIT_LAT + 2 + UNIT_LAT + 2 + UNIT_LAT + 1;
  localparam int FL_D      = TOT_LAT - 1 - FRONT_LAT;
  localparam int LM_D      = 2 + UNIT_LAT + 1;
  localparam int SD_D      = UNIT_LAT;

  localparam int NT_W   = 30;
  localparam int PROD_W = 2 * NT_W;
  localparam int BIG_W  = 63;
  localparam int LG_W   = 32;
  localparam int ARG_W  = 48;
  localparam int E_W    = 42;

  localparam logic [63:0] T_CAP      = 64'h0000_0100_0000_0000;
  localparam logic [63:0] STRESS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic signed [ARG_W-1:0] ONE_Q24        = 48'sd16777216;
  localparam logic signed [ARG_W-1:0] LOG2_LOG2E_Q24 = 48'sd8871228;
  localparam logic [WORD_W-1:0] BETA_RESET = 32'h0200_0000;

  localparam logic [5:0] FB_X     = 6'd40;
  localparam logic [5:0] FB_ALPHA = 6'd24;
  localparam logic [5:0] FB_KSI   = 6'd16;
  localparam logic [5:0] FB_JAC   = 6'd48;
  localparam logic [5:0] FB_MAG   = 6'd40;
  // fraction bits of the exp2 result minus the 30-bit mantissa point
  localparam logic signed [7:0] SH_T   = -8'sd6;
  localparam logic signed [7:0] SH_OUT = -8'sd14;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_SLACK  = 2'd1,
    ST_SAT    = 2'd2,
    ST_BADVOL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_KSI   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [BIG_W-1:0]       x;
    logic signed [BIG_W-1:0]       jac;
    logic [NCOMP-1:0][PROD_W-1:0]  mag;
    logic [NCOMP-1:0]              neg;
    logic [NCOMP-1:0]              zero;
    logic                          jac_bad;
    logic                          slack;
  } geom_t;

  typedef struct packed {
    logic [NCOMP-1:0] neg;
    logic [NCOMP-1:0] zero;
    logic             jac_bad;
    logic             slack;
  } flags_t;

  function automatic logic [63:0] isqrt(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // floor(2^(2^-(k+1))) in Q.30
  function automatic logic [30:0] exp_tab(int k);
    logic [63:0] t;
    t = isqrt(64'h2000_0000_0000_0000);
    for (int i = 1; i <= k; i++) begin
      t = isqrt(t << 30);
    end
    return t[30:0];
  endfunction

endpackage
`default_nettype wire

[hdl/fiber_exp_power_stress.sv]
// Exponential-power fiber stress evaluator. Each request carries F (Q4.28, row by
// row) and a global fiber direction n0; the result carries the six Cauchy stress
// components (Q16.16, saturated to +-(2^31-1)) and a status code: 0 ok, 1 slack
// fiber, 2 saturated, 3 nonpositive det F. The pipeline accepts one request per
// clock while the output is not stalled; its result shows on m_tvalid after 84
// register stages. The depth is set by the x log2 unit, the exp2 unit for the
// alpha term and the output exp2 units in series, 25 stages each, plus four front
// stages for F*n0 and det F and a few adder stages. When the result is not taken
// the whole pipeline holds. Registers (alpha, beta, ksi) are written on the cfg
// channel, which is always ready; write them only with no request in flight.
`default_nettype none
module fiber_exp_power_stress (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // grad_xx grad_xy grad_xz grad_yx grad_yy grad_yz grad_zx grad_zy grad_zz
  // fiber_dir_x fiber_dir_y fiber_dir_z
  input  logic [fes_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // stress_xx stress_yy stress_zz stress_xy stress_yz stress_xz
  output logic [fes_pkg::OUT_W-1:0]       m_tdata,
  // status
  output logic [fes_pkg::STAT_W-1:0]      m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fes_pkg::WORD_W-1:0]      cfg_data
);

  typedef struct packed {
    logic signed [fes_pkg::E_W-1:0]  e;
    logic signed [fes_pkg::LG_W-1:0] lk;
    logic signed [fes_pkg::LG_W-1:0] lj;
  } sside_t;

  logic [fes_pkg::WORD_W-1:0] alpha;
  logic [fes_pkg::WORD_W-1:0] beta;
  logic [fes_pkg::WORD_W-1:0] ksi;

  logic                        adv;
  logic [fes_pkg::TOT_LAT:1]   vld;

  fes_pkg::geom_t  geom;
  fes_pkg::flags_t fl [fes_pkg::FL_D];

  logic signed [fes_pkg::LG_W-1:0] lx, lj, la, lk;
  logic signed [fes_pkg::LG_W-1:0] lmag [fes_pkg::NCOMP];
  logic signed [fes_pkg::LG_W-1:0] lm   [fes_pkg::LM_D][fes_pkg::NCOMP];

  logic signed [33:0]               bm1;
  logic signed [65:0]               pe;
  logic signed [64:0]               pa;
  logic signed [fes_pkg::LG_W-1:0]  la1, lk1, lj1;
  logic signed [fes_pkg::E_W-1:0]   e2;
  logic signed [fes_pkg::ARG_W-1:0] a2;
  logic signed [fes_pkg::LG_W-1:0]  lk2, lj2;
  sside_t                           sd [fes_pkg::SD_D];

  logic [63:0]                      tv;
  logic signed [fes_pkg::ARG_W-1:0] s5;
  logic signed [fes_pkg::ARG_W-1:0] arg6 [fes_pkg::NCOMP];
  logic [63:0]                      ov   [fes_pkg::NCOMP];
  logic [fes_pkg::NCOMP-1:0]        osat;

  fes_pkg::flags_t                  ff;
  logic [fes_pkg::OUT_W-1:0]        data_c;
  fes_pkg::status_t                 stat_c;

  assign cfg_ready = 1'b1;
  assign adv       = !vld[fes_pkg::TOT_LAT] || m_tready;
  assign s_tready  = adv;
  assign m_tvalid  = vld[fes_pkg::TOT_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= '0;
      beta  <= fes_pkg::BETA_RESET;
      ksi   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fes_pkg::REG_ALPHA: alpha <= cfg_data;
        fes_pkg::REG_BETA:  beta  <= cfg_data;
        fes_pkg::REG_KSI:   ksi   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[fes_pkg::TOT_LAT-1:1], s_tvalid};
    end
  end

  fes_geom u_geom (
    .clk  (clk),
    .en   (adv),
    .grad (s_tdata[fes_pkg::NGRAD*fes_pkg::WORD_W-1:0]),
    .fib  (s_tdata[fes_pkg::IN_W-1:fes_pkg::NGRAD*fes_pkg::WORD_W]),
    .geom (geom)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      fl[0] <= '{neg: geom.neg, zero: geom.zero, jac_bad: geom.jac_bad, slack: geom.slack};
      for (int i = 1; i < fes_pkg::FL_D; i++) begin
        fl[i] <= fl[i-1];
      end
    end
  end

  fes_log2 u_log_x (
    .clk (clk), .en (adv), .v (64'(geom.x)), .frac_bits (fes_pkg::FB_X), .lg (lx)
  );
  fes_log2 u_log_jac (
    .clk (clk), .en (adv), .v (64'(geom.jac)), .frac_bits (fes_pkg::FB_JAC), .lg (lj)
  );
  fes_log2 u_log_alpha (
    .clk (clk), .en (adv), .v (64'(alpha)), .frac_bits (fes_pkg::FB_ALPHA), .lg (la)
  );
  fes_log2 u_log_ksi (
    .clk (clk), .en (adv), .v (64'(ksi)), .frac_bits (fes_pkg::FB_KSI), .lg (lk)
  );

  for (genvar k = 0; k < fes_pkg::NCOMP; k++) begin : g_lmag
    fes_log2 u_log_mag (
      .clk       (clk),
      .en        (adv),
      .v         (64'(geom.mag[k])),
      .frac_bits (fes_pkg::FB_MAG),
      .lg        (lmag[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lm[0] <= lmag;
      for (int i = 1; i < fes_pkg::LM_D; i++) begin
        lm[i] <= lm[i-1];
      end
    end
  end

  // exponents: (beta-1) log2 x and alpha * x^beta in the log domain
  assign bm1 = $signed({2'b00, beta}) - 34'sd16777216;

  always_ff @(posedge clk) begin
    if (adv) begin
      pe  <= 66'(bm1) * 66'(lx);
      pa  <= 65'($signed({1'b0, beta})) * 65'(lx);
      la1 <= la;
      lk1 <= lk;
      lj1 <= lj;
      e2  <= pe[65:24];
      a2  <= fes_pkg::ARG_W'(la1) + fes_pkg::ARG_W'($signed(pa[64:24]))
           + fes_pkg::LOG2_LOG2E_Q24;
      lk2 <= lk1;
      lj2 <= lj1;
    end
  end

  fes_exp2 u_exp_t (
    .clk     (clk),
    .en      (adv),
    .arg     (a2),
    .sh_offs (fes_pkg::SH_T),
    .lim     (fes_pkg::T_CAP),
    .v       (tv),
    .sat     ()
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= '{e: e2, lk: lk2, lj: lj2};
      for (int i = 1; i < fes_pkg::SD_D; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5 <= fes_pkg::ONE_Q24 + fes_pkg::ARG_W'(sd[fes_pkg::SD_D-1].lk)
          + fes_pkg::ARG_W'(sd[fes_pkg::SD_D-1].e)
          + ((alpha != '0) ? fes_pkg::ARG_W'(tv[40:0]) : '0)
          - fes_pkg::ARG_W'(sd[fes_pkg::SD_D-1].lj);
      for (int k = 0; k < fes_pkg::NCOMP; k++) begin
        arg6[k] <= fes_pkg::ARG_W'(lm[fes_pkg::LM_D-1][k]) + s5;
      end
    end
  end

  for (genvar k = 0; k < fes_pkg::NCOMP; k++) begin : g_out
    fes_exp2 u_exp_out (
      .clk     (clk),
      .en      (adv),
      .arg     (arg6[k]),
      .sh_offs (fes_pkg::SH_OUT),
      .lim     (fes_pkg::STRESS_LIM),
      .v       (ov[k]),
      .sat     (osat[k])
    );
  end

  always_comb begin
    ff     = fl[fes_pkg::FL_D-1];
    data_c = '0;
    stat_c = fes_pkg::ST_OK;
    if (ff.jac_bad) begin
      stat_c = fes_pkg::ST_BADVOL;
    end else if (ff.slack) begin
      stat_c = fes_pkg::ST_SLACK;
    end else if (ksi != '0) begin
      for (int k = 0; k < fes_pkg::NCOMP; k++) begin
        if (!ff.zero[k]) begin
          data_c[k*fes_pkg::WORD_W +: fes_pkg::WORD_W] =
            ff.neg[k] ? -ov[k][fes_pkg::WORD_W-1:0] : ov[k][fes_pkg::WORD_W-1:0];
          if (osat[k]) begin
            stat_c = fes_pkg::ST_SAT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= data_c;
      m_tuser <= stat_c;
    end
  end

endmodule
`default_nettype wire

[hdl/fes_geom.sv]
`default_nettype none
module fes_geom (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [fes_pkg::NGRAD-1:0][fes_pkg::WORD_W-1:0] grad,
  input  logic [fes_pkg::NDIR-1:0][fes_pkg::WORD_W-1:0]  fib,
  output fes_pkg::geom_t                                 geom
);

  logic signed [63:0] fn1 [fes_pkg::NGRAD];
  logic signed [63:0] mp1 [6];
  logic signed [31:0] frow1 [3];

  logic signed [fes_pkg::NT_W-1:0] nt_c [3];
  logic signed [64:0]              dm [3];
  logic signed [fes_pkg::NT_W-1:0] nt2 [3];
  logic signed [28:0]              mn2 [3];
  logic signed [31:0]              frow2 [3];

  logic signed [fes_pkg::PROD_W-1:0] p3 [fes_pkg::NCOMP];
  logic signed [60:0]                jp3 [3];

  fes_pkg::geom_t g_c;

  // products of F with n0, and the products for the 2x2 minors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          fn1[3*i+j] <= 64'($signed(grad[3*i+j])) * 64'($signed(fib[j]));
        end
        frow1[i] <= $signed(grad[i]);
      end
      mp1[0] <= 64'($signed(grad[4])) * 64'($signed(grad[8]));
      mp1[1] <= 64'($signed(grad[5])) * 64'($signed(grad[7]));
      mp1[2] <= 64'($signed(grad[3])) * 64'($signed(grad[8]));
      mp1[3] <= 64'($signed(grad[5])) * 64'($signed(grad[6]));
      mp1[4] <= 64'($signed(grad[3])) * 64'($signed(grad[7]));
      mp1[5] <= 64'($signed(grad[4])) * 64'($signed(grad[6]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nt_c[i] = fes_pkg::NT_W'($signed(fn1[3*i][63:36]))
              + fes_pkg::NT_W'($signed(fn1[3*i+1][63:36]))
              + fes_pkg::NT_W'($signed(fn1[3*i+2][63:36]));
      dm[i] = 65'(mp1[2*i]) - 65'(mp1[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nt2[i]   <= nt_c[i];
        mn2[i]   <= $signed(dm[i][64:36]);
        frow2[i] <= frow1[i];
      end
    end
  end

  // component order: xx yy zz xy yz xz
  always_ff @(posedge clk) begin
    if (en) begin
      p3[0] <= fes_pkg::PROD_W'(nt2[0]) * fes_pkg::PROD_W'(nt2[0]);
      p3[1] <= fes_pkg::PROD_W'(nt2[1]) * fes_pkg::PROD_W'(nt2[1]);
      p3[2] <= fes_pkg::PROD_W'(nt2[2]) * fes_pkg::PROD_W'(nt2[2]);
      p3[3] <= fes_pkg::PROD_W'(nt2[0]) * fes_pkg::PROD_W'(nt2[1]);
      p3[4] <= fes_pkg::PROD_W'(nt2[1]) * fes_pkg::PROD_W'(nt2[2]);
      p3[5] <= fes_pkg::PROD_W'(nt2[0]) * fes_pkg::PROD_W'(nt2[2]);
      for (int i = 0; i < 3; i++) begin
        jp3[i] <= 61'(frow2[i]) * 61'(mn2[i]);
      end
    end
  end

  always_comb begin
    g_c.x = fes_pkg::BIG_W'(p3[0]) + fes_pkg::BIG_W'(p3[1]) + fes_pkg::BIG_W'(p3[2])
          - 63'sh100_0000_0000;
    g_c.jac = fes_pkg::BIG_W'(jp3[0]) - fes_pkg::BIG_W'(jp3[1]) + fes_pkg::BIG_W'(jp3[2]);
    for (int k = 0; k < fes_pkg::NCOMP; k++) begin
      g_c.neg[k]  = p3[k][fes_pkg::PROD_W-1];
      g_c.zero[k] = (p3[k] == '0);
      g_c.mag[k]  = p3[k][fes_pkg::PROD_W-1] ? fes_pkg::PROD_W'(-p3[k])
                                              : fes_pkg::PROD_W'(p3[k]);
    end
    g_c.jac_bad = g_c.jac[fes_pkg::BIG_W-1] || (g_c.jac == '0);
    g_c.slack   = g_c.x[fes_pkg::BIG_W-1] || (g_c.x == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom <= g_c;
    end
  end

endmodule
`default_nettype wire

[hdl/fes_log2.sv]
`default_nettype none
module fes_log2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic [63:0]                       v,
  input  logic [5:0]                        frac_bits,
  output logic signed [fes_pkg::LG_W-1:0]   lg
);

  logic [63:0] w;
  logic [5:0]  cnt;

  logic [5:0]                p  [fes_pkg::UNIT_LAT];
  logic [30:0]               m  [fes_pkg::UNIT_LAT];
  logic [fes_pkg::ITERS-1:0] fr [fes_pkg::UNIT_LAT];

  logic [7:0] ip_diff;

  // leading-one search in six halving steps
  always_comb begin
    w   = v;
    cnt = '0;
    if (w[63:32] == '0) begin
      w = w << 32;
      cnt[5] = 1'b1;
    end
    if (w[63:48] == '0) begin
      w = w << 16;
      cnt[4] = 1'b1;
    end
    if (w[63:56] == '0) begin
      w = w << 8;
      cnt[3] = 1'b1;
    end
    if (w[63:60] == '0) begin
      w = w << 4;
      cnt[2] = 1'b1;
    end
    if (w[63:62] == '0) begin
      w = w << 2;
      cnt[1] = 1'b1;
    end
    if (!w[63]) begin
      w = w << 1;
      cnt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0]  <= ~cnt;
      m[0]  <= w[63:33];
      fr[0] <= '0;
    end
  end

  // squaring the mantissa yields one fraction bit per stage
  for (genvar k = 1; k <= fes_pkg::ITERS; k++) begin : g_iter
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(m[k-1]) * 62'(m[k-1]);
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        p[k] <= p[k-1];
        if (t[31]) begin
          m[k]  <= t[31:1];
          fr[k] <= {fr[k-1][fes_pkg::ITERS-2:0], 1'b1};
        end else begin
          m[k]  <= t[30:0];
          fr[k] <= {fr[k-1][fes_pkg::ITERS-2:0], 1'b0};
        end
      end
    end
  end

  assign ip_diff = {2'b00, p[fes_pkg::ITERS]} - {2'b00, frac_bits};
  assign lg      = $signed({ip_diff, fr[fes_pkg::ITERS]});

endmodule
`default_nettype wire

[hdl/fes_exp2.sv]
`default_nettype none
module fes_exp2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fes_pkg::ARG_W-1:0]  arg,
  input  logic signed [7:0]                 sh_offs,
  input  logic [63:0]                       lim,
  output logic [63:0]                       v,
  output logic                              sat
);

  localparam logic [30:0] TAB0 = fes_pkg::exp_tab(0);

  logic signed [23:0]        ip_r [1:fes_pkg::ITERS];
  logic [fes_pkg::ITERS-1:0] fr_r [1:fes_pkg::ITERS];
  logic [30:0]               m_r  [1:fes_pkg::ITERS];

  logic signed [25:0] sh;
  logic signed [25:0] nsh;
  logic [63:0]        shl;
  logic [63:0]        shr;
  logic [63:0]        v_c;
  logic               sat_c;

  // top fraction bit needs no multiply: 2^30 times the table entry
  always_ff @(posedge clk) begin
    if (en) begin
      ip_r[1] <= arg[fes_pkg::ARG_W-1:24];
      fr_r[1] <= arg[23:0];
      m_r[1]  <= arg[23] ? TAB0 : 31'h4000_0000;
    end
  end

  for (genvar k = 2; k <= fes_pkg::ITERS; k++) begin : g_iter
    localparam logic [30:0] TK = fes_pkg::exp_tab(k - 1);
    logic [61:0] pr;
    assign pr = 62'(m_r[k-1]) * 62'(TK);
    always_ff @(posedge clk) begin
      if (en) begin
        ip_r[k] <= ip_r[k-1];
        fr_r[k] <= fr_r[k-1];
        m_r[k]  <= fr_r[k-1][fes_pkg::ITERS-k] ? pr[60:30] : m_r[k-1];
      end
    end
  end

  always_comb begin
    sh    = 26'(ip_r[fes_pkg::ITERS]) + 26'(sh_offs);
    nsh   = -sh;
    shl   = {33'b0, m_r[fes_pkg::ITERS]} << sh[5:0];
    shr   = {33'b0, m_r[fes_pkg::ITERS]} >> nsh[5:0];
    v_c   = '0;
    sat_c = 1'b0;
    if (sh >= 26'sd34) begin
      v_c   = lim;
      sat_c = 1'b1;
    end else if (sh >= 26'sd0) begin
      if (shl >= lim) begin
        v_c   = lim;
        sat_c = (shl > lim);
      end else begin
        v_c = shl;
      end
    end else if (sh > -26'sd64) begin
      v_c = shr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v   <= v_c;
      sat <= sat_c;
    end
  end

endmodule
`default_nettype wire

[hdl/fes_checker.sv]
`default_nettype none
module fes_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fes_pkg::OUT_W-1:0]     m_tdata,
  input logic [fes_pkg::STAT_W-1:0]    m_tuser
);

  // slack fiber and bad volume carry an all-zero stress
  a_zero_on_reject: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == fes_pkg::ST_SLACK || m_tuser == fes_pkg::ST_BADVOL)
    |-> m_tdata == '0)
    else $error("nonzero stress with slack or bad volume status");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // with no result pending the pipeline must take requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // saturation is symmetric: the most negative code never appears
  a_sym_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:0] != 32'h8000_0000 && m_tdata[63:32] != 32'h8000_0000
      && m_tdata[95:64] != 32'h8000_0000 && m_tdata[127:96] != 32'h8000_0000
      && m_tdata[159:128] != 32'h8000_0000 && m_tdata[191:160] != 32'h8000_0000)
    else $error("stress outside symmetric range");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind fiber_exp_power_stress fes_checker u_fes_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

[dv/tb_fiber_exp_power_stress.sv]
`timescale 1ns / 1ps
module tb_fiber_exp_power_stress;

  localparam int         ONE_F     = 1 << 28;   // 1.0 in Q4.28
  localparam longint     ONE_L     = 64'sd16777216;
  localparam int         PHASES    = 7;
  localparam int         PER_PHASE = 150;

  typedef logic [11:0][31:0] point_t;
  typedef struct {
    logic [5:0][31:0]  sig;
    fes_pkg::status_t  st;
  } stress_t;
  typedef struct {
    point_t            pt;
    bit                known;
    fes_pkg::status_t  st;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [fes_pkg::IN_W-1:0]      s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [fes_pkg::OUT_W-1:0]     m_tdata;
  logic [fes_pkg::STAT_W-1:0]    m_tuser;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fes_pkg::WORD_W-1:0]    cfg_data;

  fiber_exp_power_stress i_dut (.*);

  always #10 clk = ~clk;

  logic [31:0]           alpha_r, beta_r, ksi_r;
  longint unsigned       root_tab [24];
  stress_t               pending_stress[$];
  int                    mismatches = 0;
  int                    n_points = 0, n_results = 0;
  int                    n_stat [4] = '{0, 0, 0, 0};
  bit                    quiet = 1'b0;
  int                    ready_wait = 0;
  string                 comp_name [6] = '{"stress_xx", "stress_yy", "stress_zz",
                                           "stress_xy", "stress_yz", "stress_xz"};

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2 of a positive value with fb fraction bits, Q.24
  function automatic longint log2_q24(longint unsigned v, int fb);
    int              p;
    longint unsigned m;
    longint          fr;
    p = 63;
    fr = 0;
    while (p > 0 && !v[p]) p--;
    m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd1 << 31)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return longint'(p - fb) * ONE_L + fr;
  endfunction

  function automatic longint unsigned exp2_q24(longint arg, int fb, longint unsigned lim,
                                               inout bit sat);
    longint          ip, sh;
    longint unsigned fr, m, v;
    ip = arg >>> 24;
    fr = longint'(arg - ip * ONE_L);
    m = 64'd1 << 30;
    for (int k = 0; k < 24; k++)
      if (fr[23-k]) m = (m * root_tab[k]) >> 30;
    sh = ip + fb - 30;
    if (sh >= 34) begin
      sat = 1'b1;
      return lim;
    end
    if (sh >= 0) begin
      v = m << sh;
      if (v >= lim) begin
        if (v > lim) sat = 1'b1;
        return lim;
      end
      return v;
    end
    if (sh <= -64) return 0;
    return m >> (-sh);
  endfunction

  function automatic stress_t fiber_stress(point_t pt);
    stress_t         res;
    longint          f [9], n [3], nt [3];
    longint          in2, x, m0, m1, m2, jac, lx, e, t, s, p;
    longint unsigned mag, v;
    bit              sat, tsat;
    int              pi [6] = '{0, 1, 2, 0, 1, 0};
    int              pj [6] = '{0, 1, 2, 1, 2, 2};
    res.sig = '0;
    res.st = fes_pkg::ST_OK;
    sat = 1'b0;
    tsat = 1'b0;
    in2 = 0;
    for (int i = 0; i < 9; i++) f[i] = longint'(signed'(pt[i]));
    for (int i = 0; i < 3; i++) n[i] = longint'(signed'(pt[9+i]));
    for (int i = 0; i < 3; i++) begin
      nt[i] = ((f[3*i] * n[0]) >>> 36) + ((f[3*i+1] * n[1]) >>> 36)
            + ((f[3*i+2] * n[2]) >>> 36);
      in2 += nt[i] * nt[i];
    end
    x = in2 - (64'sd1 <<< 40);
    m0 = (f[4] * f[8] - f[5] * f[7]) >>> 36;
    m1 = (f[3] * f[8] - f[5] * f[6]) >>> 36;
    m2 = (f[3] * f[7] - f[4] * f[6]) >>> 36;
    jac = f[0] * m0 - f[1] * m1 + f[2] * m2;
    if (jac <= 0) begin
      res.st = fes_pkg::ST_BADVOL;
      return res;
    end
    if (x <= 0) begin
      res.st = fes_pkg::ST_SLACK;
      return res;
    end
    if (ksi_r == 0) return res;
    lx = log2_q24(x, 40);
    e = ((longint'(beta_r) - ONE_L) * lx) >>> 24;
    t = 0;
    if (alpha_r != 0)
      t = longint'(exp2_q24(log2_q24(alpha_r, 24) + ((longint'(beta_r) * lx) >>> 24)
                            + 64'sd8871228, 24, 64'd1 << 40, tsat));
    s = ONE_L + log2_q24(ksi_r, 16) + e + t - log2_q24(jac, 48);
    for (int k = 0; k < 6; k++) begin
      p = nt[pi[k]] * nt[pj[k]];
      if (p != 0) begin
        mag = (p < 0) ? -p : p;
        v = exp2_q24(log2_q24(mag, 40) + s, 16, 64'h7FFF_FFFF, sat);
        res.sig[k] = (p < 0) ? -v[31:0] : v[31:0];
      end
    end
    if (sat) res.st = fes_pkg::ST_SAT;
    return res;
  endfunction

  function automatic point_t mk_point(int gxx, int gxy, int gxz, int gyx, int gyy, int gyz,
                                      int gzx, int gzy, int gzz, int nx, int ny, int nz);
    point_t pt;
    pt[0] = gxx; pt[1] = gxy; pt[2] = gxz;
    pt[3] = gyx; pt[4] = gyy; pt[5] = gyz;
    pt[6] = gzx; pt[7] = gzy; pt[8] = gzz;
    pt[9] = nx;  pt[10] = ny; pt[11] = nz;
    return pt;
  endfunction

  function automatic int spread(int mid, int half);
    return mid + int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // mostly a mild stretch of a single-axis fiber, sometimes raw bits
  function automatic point_t rand_point();
    point_t pt;
    int     mode, ax;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < 12; i++) pt[i] = $urandom;
      return pt;
    end
    for (int i = 0; i < 9; i++)
      pt[i] = (i % 4 == 0) ? spread(mode == 1 ? ONE_F * 3 / 4 : ONE_F * 5 / 4, ONE_F / 4)
                           : spread(0, ONE_F / 8);
    if (mode == 2) pt[$urandom_range(0, 8)] = spread(0, ONE_F * 2);
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      pt[9+i] = (i == ax) ? ($urandom_range(0, 1) ? ONE_F : -ONE_F)
              : ($urandom_range(0, 2) == 0 ? 0 : spread(0, ONE_F / 8));
    return pt;
  endfunction

  task automatic send_point(point_t pt, stress_t want);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pt;
    do @(posedge clk); while (!s_tready);
    pending_stress.push_back(want);
    n_points++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(fes_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fes_pkg::REG_ALPHA: alpha_r = val;
      fes_pkg::REG_BETA:  beta_r  = val;
      default:            ksi_r   = val;
    endcase
  endtask

  // result side: random stall after each taken result, none in quiet phases
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_wait = 0;
    end else if (m_tvalid && m_tready) begin
      stress_t got, want;
      got.sig = m_tdata;
      got.st  = fes_pkg::status_t'(m_tuser);
      n_results++;
      if (pending_stress.size() == 0) begin
        $error("result with nothing expected");
        mismatches++;
      end else begin
        want = pending_stress.pop_front();
        for (int k = 0; k < 6; k++)
          if (got.sig[k] !== want.sig[k]) begin
            $error("%s expected %h got %h", comp_name[k], want.sig[k], got.sig[k]);
            mismatches++;
          end
        if (got.st !== want.st) begin
          $error("status expected %0d got %0d", want.st, got.st);
          mismatches++;
        end
        n_stat[want.st]++;
      end
      ready_wait = quiet ? 0 : $urandom_range(0, 5);
      m_tready <= (ready_wait == 0);
    end else if (!m_tready) begin
      if (ready_wait > 1) ready_wait--;
      else begin
        ready_wait = 0;
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    dir_row_t    dir_rows [$];
    stress_t     want;
    logic [31:0] cfg_set [PHASES][3];
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    alpha_r = 0;
    beta_r  = 32'h0200_0000;
    ksi_r   = 0;
    root_tab[0] = root_floor(64'd2 << 60);
    for (int k = 1; k < 24; k++) root_tab[k] = root_floor(root_tab[k-1] << 30);

    // reset settings: ksi is zero, so any good tension row is all zeros
    dir_rows = '{
      '{mk_point(ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F, ONE_F, 0, 0), 1, fes_pkg::ST_SLACK},
      '{mk_point(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE_F, 0, 0), 1, fes_pkg::ST_BADVOL},
      '{mk_point(ONE_F, 0, 0, 0, ONE_F, 0, 0, 0, ONE_F, 0, 0, 0), 1, fes_pkg::ST_SLACK},
      '{mk_point(2*ONE_F, 0, 0, 0, 2*ONE_F, 0, 0, 0, 2*ONE_F, ONE_F, 0, 0), 1,
        fes_pkg::ST_OK},
      '{mk_point(-ONE_F, 0, 0, 0, -ONE_F, 0, 0, 0, -ONE_F, ONE_F, 0, 0), 1,
        fes_pkg::ST_BADVOL},
      '{mk_point('1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1, '1 >>> 1,
                 '1 >>> 1, '1 >>> 1, ONE_F, 0, 0), 1, fes_pkg::ST_BADVOL},
      '{mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1,
        fes_pkg::ST_BADVOL},
      '{mk_point(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1, fes_pkg::ST_OK},
      '{mk_point(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000,
                 ONE_F, 0, 0), 1, fes_pkg::ST_BADVOL},
      '{mk_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555), 0,
        fes_pkg::ST_OK},
      '{mk_point(ONE_F, ONE_F / 4, 0, 0, ONE_F, -ONE_F / 4, 0, 0, ONE_F,
                 ONE_F, ONE_F, -ONE_F), 0, fes_pkg::ST_OK},
      '{mk_point(0, ONE_F, 0, ONE_F, 0, 0, 0, 0, ONE_F, ONE_F, 0, 0), 1,
        fes_pkg::ST_BADVOL}
    };

    // alpha Q8.24, beta Q8.24, ksi Q16.16
    cfg_set = '{
      '{32'd0,         32'h0200_0000, 32'h0001_0000},
      '{32'h0080_0000, 32'h0200_0000, 32'h0002_0000},
      '{32'h0100_0000, 32'h0300_0000, 32'h0000_4000},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'd0,         32'h0100_0000, 32'h0001_0000},   // beta below its range
      '{32'h0040_0000, 32'h0280_0000, 32'h0064_0000},
      '{$urandom_range(0, 32'h0200_0000), $urandom_range(32'h0200_0000, 32'h0400_0000),
        $urandom}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].known) begin
        want.sig = '0;
        want.st  = dir_rows[r].st;
      end else begin
        want = fiber_stress(dir_rows[r].pt);
      end
      send_point(dir_rows[r].pt, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      s_tvalid <= 1'b0;
      while (pending_stress.size() != 0) @(posedge clk);
      @(posedge clk);
      write_reg(fes_pkg::REG_ALPHA, cfg_set[ph][0]);
      write_reg(fes_pkg::REG_BETA,  cfg_set[ph][1]);
      write_reg(fes_pkg::REG_KSI,   cfg_set[ph][2]);
      cfg_valid <= 1'b0;
      quiet = (ph % 3 == 2);
      for (int i = 0; i < PER_PHASE; i++) begin
        point_t pt;
        pt = rand_point();
        send_point(pt, fiber_stress(pt));
      end
    end
    s_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_stress.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d points sent over %0d register settings, %0d results checked",
             n_points, PHASES + 1, n_results);
    $display("status seen: ok %0d, slack %0d, saturated %0d, bad volume %0d",
             n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
    if (mismatches == 0 && pending_stress.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
hdl/fes_pkg.sv
hdl/fes_geom.sv
hdl/fes_log2.sv
hdl/fes_exp2.sv
hdl/fiber_exp_power_stress.sv
hdl/fes_checker.sv
dv/tb_fiber_exp_power_stress.sv
